// File: hdl/assert_macros.svh
// Assertion macros shared by the checker files of the pool allocator.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define FSPA_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Shorthand on the house clock and reset names.
`define FSPA_ASSERT(lbl, prop, msg) `FSPA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: hdl/fspa_pkg.sv
// Shared types, codes and constants of the fixed-slot pool allocator.
// No dependencies; used by the interface users, the free-map memory and the checker.
package fspa_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 1024;

  localparam int unsigned CNT_W      = 11;
  localparam int unsigned SZL_W      = 4;
  localparam int unsigned REQ_W      = 15;
  localparam int unsigned OFF_W      = 25;
  localparam int unsigned SIDX_W     = 10;
  localparam int unsigned WASTE_W    = 48;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  // widest free-map word
  localparam int unsigned MAP_WORD_MAX = 32;

  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 11'd1024;
  localparam logic [SZL_W-1:0] SLOT_LOG2_RST  = 4'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_COUNT     = 1'b0,
    REG_SLOT_SIZE_LOG2 = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    STAT_ALLOCATED = 3'd0,
    STAT_TOO_BIG   = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_FREED     = 3'd3,
    STAT_NOT_OWNED = 3'd4
  } status_e;

  typedef struct packed {
    mode_e              mode;
    logic [REQ_W-1:0]   request_size;
    logic [OFF_W-1:0]   free_offset;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [SIDX_W-1:0]  slot_index;
    logic [OFF_W-1:0]   byte_offset;
    logic [CNT_W-1:0]   in_use;
    logic [CNT_W-1:0]   peak_in_use;
    logic [WASTE_W-1:0] wasted_total;
    logic               misaligned;
    logic               double_free;
    logic               count_underflow;
  } rsp_t;

  // bits per free-map word: a full word, or the whole pool when it is smaller
  function automatic int unsigned map_word_w(input int unsigned slots);
    int unsigned w;
    w = (slots < MAP_WORD_MAX) ? (1 << $clog2(slots)) : MAP_WORD_MAX;
    return w;
  endfunction

endpackage

// File: hdl/fspa_stream_if.sv
// Valid/ready stream channel with a typed payload.
// No dependencies; the payload type is set where the channel is instantiated.
interface fspa_stream_if #(
  parameter type PayloadT = logic
) ();

  logic    valid;
  logic    ready;
  PayloadT payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// File: hdl/fspa_free_map.sv
// Free bitmap of the pool: word-wide RAM, two registered read ports, a summary bit per word.
// Depends on fspa_pkg; instantiated by fixed_slot_pool_allocator.
module fspa_free_map import fspa_pkg::*; #(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF,
  localparam int unsigned IdxW      = $clog2(MAX_SLOTS),
  localparam int unsigned WordW     = map_word_w(MAX_SLOTS),
  localparam int unsigned BitW      = $clog2(WordW),
  localparam int unsigned WordsLog2 = IdxW - BitW,
  localparam int unsigned NumWords  = 1 << WordsLog2,
  localparam int unsigned AddrW     = (WordsLog2 > 0) ? WordsLog2 : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [AddrW-1:0] rd_a_addr_i,
  input  logic [AddrW-1:0] rd_b_addr_i,
  output logic [WordW-1:0] rd_a_data_o,
  output logic [WordW-1:0] rd_b_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WordW-1:0] wr_data_i,
  output logic             busy_o,
  output logic             any_free_o,
  output logic [AddrW-1:0] first_word_o
);

  logic [WordW-1:0]    mem_q [NumWords];
  logic [WordW-1:0]    rd_a_q;
  logic [WordW-1:0]    rd_b_q;
  logic [NumWords-1:0] sum_q;
  logic                busy_q;
  logic [AddrW-1:0]    clr_addr_q;
  logic                wen;
  logic [AddrW-1:0]    waddr;
  logic [WordW-1:0]    wdata;
  logic [AddrW-1:0]    first_word;

  // the clearing sweep owns the write port until it is done
  always_comb begin
    wen   = busy_q | wr_en_i;
    waddr = busy_q ? clr_addr_q : wr_addr_i;
    wdata = busy_q ? '1 : wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else if (busy_q) begin
      if (clr_addr_q == AddrW'(NumWords - 1)) begin
        busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[waddr] <= wdata;
    end
    rd_a_q <= mem_q[rd_a_addr_i];
    rd_b_q <= mem_q[rd_b_addr_i];
  end

  // one bit per word: word still holds a free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '1;
    end else if (wen) begin
      sum_q[waddr] <= |wdata;
    end
  end

  // lowest word with a free slot
  always_comb begin
    first_word = '0;
    for (int i = NumWords - 1; i >= 0; i--) begin
      if (sum_q[i]) begin
        first_word = AddrW'(i);
      end
    end
  end

  assign rd_a_data_o  = rd_a_q;
  assign rd_b_data_o  = rd_b_q;
  assign busy_o       = busy_q;
  assign any_free_o   = |sum_q;
  assign first_word_o = first_word;

endmodule

// File: hdl/fixed_slot_pool_allocator.sv
// Fixed-slot pool allocator: free bitmap in RAM, hint slot, usage and waste counters.
// Depends on fspa_pkg, fspa_stream_if and fspa_free_map.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+-------------------------------------------
//   req_i    | in  | valid/ready         | mode, request_size, free_offset
//   rsp_o    | out | valid/ready         | status, slot_index, byte_offset, counters,
//            |     |                     | misaligned, double_free, count_underflow
//   cfg      | in  | cfg_we_i, no stall  | cfg_idx_i selects the register, cfg_data_i
//
// A request is not accepted until the last one has left S_NEXT; its steps are one free-map read
// for the candidate words, one for the neighbour word of an allocated slot, and the load of
// the result register. Ready returns and the result becomes valid together as S_NEXT ends.
// After reset a clearing pass fills the free map, one word per cycle (NumWords words,
// 32 at the default size); req_i.ready stays low until it ends, configuration still writes.
// A result not taken holds the sequencer in its last step; the next request waits for it.
module fixed_slot_pool_allocator import fspa_pkg::*; #(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  fspa_stream_if.sink           req_i,
  fspa_stream_if.source         rsp_o
);

  localparam int unsigned IdxW      = $clog2(MAX_SLOTS);
  localparam int unsigned WordW     = map_word_w(MAX_SLOTS);
  localparam int unsigned BitW      = $clog2(WordW);
  localparam int unsigned WordsLog2 = IdxW - BitW;
  localparam int unsigned AddrW     = (WordsLog2 > 0) ? WordsLog2 : 1;
  // slot indices and counts compared at a common width
  localparam int unsigned LimW      = (IdxW + 1 > CNT_W) ? IdxW + 1 : CNT_W;
  // slot size in bytes reaches 2**15
  localparam int unsigned SbW       = REQ_W + 1;
  // pool size in bytes, count shifted by the size exponent
  localparam int unsigned LimitW    = OFF_W + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PICK = 3'b010,
    S_NEXT = 3'b100
  } state_e;

  // control state
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     slot_count_q, slot_count_d;
  logic [SZL_W-1:0]     slot_log2_q, slot_log2_d;
  logic                 hint_valid_q, hint_valid_d;
  logic [IdxW-1:0]      hint_slot_q, hint_slot_d;
  logic [CNT_W-1:0]     taken_q, taken_d;
  logic [CNT_W-1:0]     peak_q, peak_d;
  logic [WASTE_W-1:0]   waste_q, waste_d;
  logic                 out_valid_q, out_valid_d;

  // request and result staging
  req_t                 req_q;
  logic [IdxW-1:0]      idx_q;
  logic [AddrW-1:0]     b_word_q;
  logic                 any_free_q;
  status_e              res_status_q, res_status_d;
  logic [IdxW-1:0]      res_idx_q, res_idx_d;
  logic                 res_mis_q, res_mis_d;
  logic                 res_dbl_q, res_dbl_d;
  logic                 res_under_q, res_under_d;
  logic                 found_q, found_d;
  logic [LimW-1:0]      nxt_q;
  rsp_t                 out_q, out_d;

  // free-map port
  logic [AddrW-1:0]     rd_a_addr, rd_b_addr;
  logic [WordW-1:0]     rd_a_data, rd_b_data;
  logic                 map_wr_en;
  logic [AddrW-1:0]     map_wr_addr;
  logic [WordW-1:0]     map_wr_data;
  logic                 map_busy;
  logic                 map_any_free;
  logic [AddrW-1:0]     map_first_word;

  // datapath
  logic                 req_accept;
  logic                 out_free;
  logic [CNT_W-1:0]     n_slots;
  logic [SbW-1:0]       slot_bytes;
  logic [OFF_W-1:0]     off_idx;
  logic                 too_big;
  logic                 pool_full;
  logic [BitW-1:0]      hint_bit;
  logic                 hint_ok;
  logic [BitW-1:0]      ff_bit;
  logic [IdxW-1:0]      ff_idx;
  logic                 ff_ok;
  logic [IdxW-1:0]      pick_idx;
  logic [WordW-1:0]     pick_word;
  logic [LimW-1:0]      nxt;
  logic                 alloc_ok;
  logic [LimitW-1:0]    pool_limit;
  logic                 not_owned;
  logic [BitW-1:0]      free_bit;
  logic                 free_mis;
  logic [SbW-1:0]       waste_inc;
  logic [WASTE_W:0]     waste_sum;
  logic [CNT_W-1:0]     taken_inc;
  logic                 next_free;

  fspa_free_map #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_free_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_a_addr_i  (rd_a_addr),
    .rd_b_addr_i  (rd_b_addr),
    .rd_a_data_o  (rd_a_data),
    .rd_b_data_o  (rd_b_data),
    .wr_en_i      (map_wr_en),
    .wr_addr_i    (map_wr_addr),
    .wr_data_i    (map_wr_data),
    .busy_o       (map_busy),
    .any_free_o   (map_any_free),
    .first_word_o (map_first_word)
  );

  assign req_i.ready   = (state_q == S_IDLE) && !map_busy;
  assign req_accept    = req_i.valid && req_i.ready;
  assign out_free      = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // slots actually usable: the register, capped at the pool size
  assign n_slots = (LimW'(slot_count_q) < LimW'(MAX_SLOTS)) ? slot_count_q : CNT_W'(MAX_SLOTS);
  assign slot_bytes = SbW'(1) << slot_log2_q;
  assign off_idx    = req_i.payload.free_offset >> slot_log2_q;

  // ---- allocate: choose a slot from the two candidate words ----
  assign too_big   = {1'b0, req_q.request_size} > slot_bytes;
  assign pool_full = taken_q >= n_slots;
  assign hint_bit  = hint_slot_q[BitW-1:0];
  assign hint_ok   = hint_valid_q && (LimW'(hint_slot_q) < LimW'(n_slots)) &&
                     rd_a_data[hint_bit];

  always_comb begin
    ff_bit = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (rd_b_data[i]) begin
        ff_bit = BitW'(i);
      end
    end
  end

  assign ff_idx    = IdxW'({b_word_q, ff_bit});
  // the lowest free slot overall may lie at or above the count: then nothing fits
  assign ff_ok     = any_free_q && (|rd_b_data) && (LimW'(ff_idx) < LimW'(n_slots));
  assign pick_idx  = hint_ok ? hint_slot_q : ff_idx;
  assign pick_word = hint_ok ? rd_a_data : rd_b_data;
  assign nxt       = LimW'(pick_idx) + LimW'(1);
  assign alloc_ok  = !too_big && !pool_full && (hint_ok || ff_ok);
  assign waste_inc = slot_bytes - {1'b0, req_q.request_size};
  assign waste_sum = {1'b0, waste_q} + (WASTE_W + 1)'(waste_inc);
  assign taken_inc = taken_q + CNT_W'(1);

  // ---- free: ownership, alignment, double free ----
  assign pool_limit = LimitW'(n_slots) << slot_log2_q;
  assign not_owned  = LimitW'(req_q.free_offset) >= pool_limit;
  assign free_bit   = idx_q[BitW-1:0];
  assign free_mis   = (req_q.free_offset & OFF_W'(slot_bytes - SbW'(1))) != '0;

  // neighbour of the allocated slot, read back in the last step
  assign next_free  = found_q && (nxt_q < LimW'(n_slots)) && rd_a_data[nxt_q[BitW-1:0]];

  // read addresses: candidates while idle, neighbour word afterwards
  always_comb begin
    rd_b_addr = b_word_q;
    rd_a_addr = AddrW'(nxt_q >> BitW);
    unique case (state_q)
      S_IDLE: begin
        rd_b_addr = map_first_word;
        rd_a_addr = (req_i.payload.mode == MODE_FREE) ? AddrW'(off_idx >> BitW)
                                                      : AddrW'(hint_slot_q >> BitW);
      end
      S_PICK:  rd_a_addr = AddrW'(nxt >> BitW);
      S_NEXT:  rd_a_addr = AddrW'(nxt_q >> BitW);
      default: rd_a_addr = AddrW'(nxt_q >> BitW);
    endcase
  end

  // read-modify-write of the chosen word; the next request reads only after it lands
  always_comb begin
    map_wr_en   = 1'b0;
    map_wr_addr = AddrW'(idx_q >> BitW);
    map_wr_data = rd_a_data | (WordW'(1) << free_bit);
    if (state_q == S_PICK) begin
      if (req_q.mode == MODE_ALLOC) begin
        map_wr_en   = alloc_ok;
        map_wr_addr = AddrW'(pick_idx >> BitW);
        map_wr_data = pick_word & ~(WordW'(1) << pick_idx[BitW-1:0]);
      end else begin
        map_wr_en   = !not_owned;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    slot_count_d = slot_count_q;
    slot_log2_d  = slot_log2_q;
    hint_valid_d = hint_valid_q;
    hint_slot_d  = hint_slot_q;
    taken_d      = taken_q;
    peak_d       = peak_q;
    waste_d      = waste_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_mis_d    = res_mis_q;
    res_dbl_d    = res_dbl_q;
    res_under_d  = res_under_q;
    found_d      = found_q;
    out_d        = out_q;

    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SLOT_COUNT:     slot_count_d = cfg_data_i;
        REG_SLOT_SIZE_LOG2: slot_log2_d  = cfg_data_i[SZL_W-1:0];
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_accept) begin
          state_d = S_PICK;
        end
      end

      // decide and commit all state but the next-slot hint
      S_PICK: begin
        state_d     = S_NEXT;
        res_idx_d   = '0;
        res_mis_d   = 1'b0;
        res_dbl_d   = 1'b0;
        res_under_d = 1'b0;
        found_d     = 1'b0;
        if (req_q.mode == MODE_ALLOC) begin
          if (too_big) begin
            res_status_d = STAT_TOO_BIG;
          end else if (!alloc_ok) begin
            res_status_d = STAT_FULL;
          end else begin
            res_status_d = STAT_ALLOCATED;
            res_idx_d    = pick_idx;
            found_d      = 1'b1;
            taken_d      = taken_inc;
            peak_d       = (taken_inc > peak_q) ? taken_inc : peak_q;
            waste_d      = waste_sum[WASTE_W] ? '1 : waste_sum[WASTE_W-1:0];
            if (hint_ok) begin
              hint_valid_d = 1'b0;
            end
          end
        end else begin
          if (not_owned) begin
            res_status_d = STAT_NOT_OWNED;
          end else begin
            res_status_d = STAT_FREED;
            res_idx_d    = idx_q;
            res_mis_d    = free_mis;
            res_dbl_d    = rd_a_data[free_bit];
            hint_slot_d  = idx_q;
            hint_valid_d = 1'b1;
            if (taken_q == '0) begin
              res_under_d = 1'b1;
            end else begin
              taken_d = taken_q - CNT_W'(1);
            end
          end
        end
      end

      // hint to the neighbour, then hand the result over
      S_NEXT: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          if (next_free) begin
            hint_slot_d  = IdxW'(nxt_q);
            hint_valid_d = 1'b1;
          end
          out_d.status          = res_status_q;
          out_d.slot_index      = SIDX_W'(res_idx_q);
          out_d.byte_offset     = OFF_W'(res_idx_q) << slot_log2_q;
          out_d.in_use          = taken_q;
          out_d.peak_in_use     = peak_q;
          out_d.wasted_total    = waste_q;
          out_d.misaligned      = res_mis_q;
          out_d.double_free     = res_dbl_q;
          out_d.count_underflow = res_under_q;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      slot_count_q <= SLOT_COUNT_RST;
      slot_log2_q  <= SLOT_LOG2_RST;
      hint_valid_q <= 1'b0;
      hint_slot_q  <= '0;
      taken_q      <= '0;
      peak_q       <= '0;
      waste_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_count_q <= slot_count_d;
      slot_log2_q  <= slot_log2_d;
      hint_valid_q <= hint_valid_d;
      hint_slot_q  <= hint_slot_d;
      taken_q      <= taken_d;
      peak_q       <= peak_d;
      waste_q      <= waste_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      req_q      <= req_i.payload;
      idx_q      <= IdxW'(off_idx);
      b_word_q   <= map_first_word;
      any_free_q <= map_any_free;
    end
    if (state_q == S_PICK) begin
      nxt_q <= nxt;
    end
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_mis_q    <= res_mis_d;
    res_dbl_q    <= res_dbl_d;
    res_under_q  <= res_under_d;
    found_q      <= found_d;
    out_q        <= out_d;
  end

endmodule

// File: hdl/fspa_checker.sv
// Port-level checks on the pool allocator, bound into the top level.
// Depends on fspa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fspa_checker import fspa_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_payload_i
);

  // a stalled result stays put
  `FSPA_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_payload_i), "result changed under stall")

  // one request in flight: ready drops right after an acceptance
  `FSPA_ASSERT(a_one_in_flight, req_valid_i && req_ready_i |=> !req_ready_i, "request accepted while busy")

  // refused requests carry no slot and no flags
  `FSPA_ASSERT(a_refused_clean, rsp_valid_i && (rsp_payload_i.status == STAT_TOO_BIG || rsp_payload_i.status == STAT_FULL || rsp_payload_i.status == STAT_NOT_OWNED) |-> rsp_payload_i.slot_index == '0 && rsp_payload_i.byte_offset == '0 && !rsp_payload_i.misaligned && !rsp_payload_i.double_free && !rsp_payload_i.count_underflow, "refused request with slot or flags")

  `FSPA_ASSERT(a_peak_bound, rsp_valid_i |-> rsp_payload_i.peak_in_use >= rsp_payload_i.in_use, "peak below in-use count")

  // an allocation leaves at least one slot taken and raises no free flags
  `FSPA_ASSERT(a_alloc_sane, rsp_valid_i && rsp_payload_i.status == STAT_ALLOCATED |-> rsp_payload_i.in_use != '0 && !rsp_payload_i.misaligned && !rsp_payload_i.double_free && !rsp_payload_i.count_underflow, "bad allocate result")

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);

// File: dv/fixed_slot_pool_allocator_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the fixed-slot pool allocator: clocked driver and monitor,
// a slot-pool predictor in SV, directed corner requests then randomised phases.
// Depends on fspa_pkg, fspa_stream_if and the fixed_slot_pool_allocator RTL.
module fixed_slot_pool_allocator_tb;
  import fspa_pkg::*;

  localparam logic [WASTE_W-1:0] WASTE_SAT = '1;
  localparam longint unsigned OFF_SPAN = 64'd1 << OFF_W;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  fspa_stream_if #(.PayloadT(req_t)) req_ch ();
  fspa_stream_if #(.PayloadT(rsp_t)) rsp_ch ();

  fixed_slot_pool_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the pool and its two registers
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]   pool_count_reg = SLOT_COUNT_RST;
  logic [SZL_W-1:0]   pool_log2_reg  = SLOT_LOG2_RST;
  bit                 free_bits [MAX_SLOTS_DEF];
  bit                 hint_live   = 1'b0;
  int unsigned        hint_idx    = 0;
  int unsigned        slots_taken = 0;
  int unsigned        slots_peak  = 0;
  longint unsigned    waste_acc   = 0;

  // Bench bookkeeping
  req_t        pending_req [$];   // requests waiting for the driver
  rsp_t        expected_rsp [$];  // predicted results, oldest first
  int          outstanding  = 0;  // queued requests whose result has not come back
  int          n_accepted   = 0;
  int          errors       = 0;
  int unsigned allocs_issued = 0; // allocates generated in the current phase
  bit          no_idle  = 1'b0;   // phase runs both sides flat out
  bit          hold_rsp = 1'b0;   // long receiver hold-off
  bit          req_fired = 1'b0;
  bit          rsp_fired = 1'b0;
  logic        drive_vld;
  int unsigned send_gap  = 0;
  int unsigned take_wait = 0;

  // ---------------------------------------------------------------------------
  // Clock, reset, quiet inputs from time zero
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Effective pool size: an over-range count is clipped to the physical slot count
  function automatic int unsigned pool_slots();
    return (pool_count_reg > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(pool_count_reg);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: one request in, the result it causes out; updates the pool copy
  // ---------------------------------------------------------------------------
  function automatic rsp_t pool_step(req_t r);
    rsp_t            o;
    int unsigned     n;
    longint unsigned slot_bytes;
    longint unsigned want;
    longint unsigned off;
    longint unsigned w;
    int unsigned     idx;
    bit              found;
    n          = pool_slots();
    slot_bytes = 64'd1 << pool_log2_reg;
    idx        = 0;
    found      = 1'b0;
    o          = '0;
    if (r.mode == MODE_ALLOC) begin
      want = r.request_size;
      if (want > slot_bytes) begin
        o.status = STAT_TOO_BIG;
      end else if (slots_taken >= n) begin
        o.status = STAT_FULL;
      end else begin
        // hint first, consumed on use; otherwise lowest free slot, hint left alone
        if (hint_live && hint_idx < n && free_bits[hint_idx]) begin
          idx       = hint_idx;
          hint_live = 1'b0;
          found     = 1'b1;
        end else begin
          for (int k = 0; k < n; k++) begin
            if (!found && free_bits[k]) begin
              idx   = k;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          free_bits[idx] = 1'b0;
          slots_taken++;
          if (slots_peak < slots_taken) slots_peak = slots_taken;
          if (want < slot_bytes) begin
            w = slot_bytes - want;
            waste_acc = (waste_acc > WASTE_SAT - w) ? WASTE_SAT : waste_acc + w;
          end
          if (idx + 1 < n && free_bits[idx + 1]) begin
            hint_idx  = idx + 1;
            hint_live = 1'b1;
          end
          o.status      = STAT_ALLOCATED;
          o.slot_index  = SIDX_W'(idx);
          o.byte_offset = OFF_W'(longint'(idx) << pool_log2_reg);
        end else begin
          // count says there is room but the map has nothing below the count
          o.status = STAT_FULL;
        end
      end
    end else begin
      off = r.free_offset;
      if (off >= (longint'(n) << pool_log2_reg)) begin
        o.status = STAT_NOT_OWNED;
      end else begin
        idx            = int'(off >> pool_log2_reg);
        o.misaligned   = (off & (slot_bytes - 1)) != 0;
        o.double_free  = free_bits[idx];
        free_bits[idx] = 1'b1;
        hint_idx       = idx;
        hint_live      = 1'b1;
        if (slots_taken == 0) o.count_underflow = 1'b1;
        else slots_taken--;
        o.status      = STAT_FREED;
        o.slot_index  = SIDX_W'(idx);
        o.byte_offset = OFF_W'(longint'(idx) << pool_log2_reg);
      end
    end
    o.in_use       = CNT_W'(slots_taken);
    o.peak_in_use  = CNT_W'(slots_peak);
    o.wasted_total = waste_acc[WASTE_W-1:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting; printing is capped, counting is not
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (errors < 100)
      $display("MISMATCH %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_field(input string what, input longint unsigned got,
                             input longint unsigned want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: samples both handshakes at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rsp_t want;
    req_fired = rst_ni && req_ch.valid && req_ch.ready;
    rsp_fired = rst_ni && rsp_ch.valid && rsp_ch.ready;
    // predict first: a result seen in the same cycle always belongs to an older request
    if (req_fired) begin
      expected_rsp.push_back(pool_step(req_ch.payload));
      n_accepted++;
    end
    if (rsp_fired) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("result with no request pending", rsp_ch.payload, 0);
      end else begin
        want = expected_rsp.pop_front();
        check_field("status", rsp_ch.payload.status, want.status);
        check_field("slot_index", rsp_ch.payload.slot_index, want.slot_index);
        check_field("byte_offset", rsp_ch.payload.byte_offset, want.byte_offset);
        check_field("in_use", rsp_ch.payload.in_use, want.in_use);
        check_field("peak_in_use", rsp_ch.payload.peak_in_use, want.peak_in_use);
        check_field("wasted_total", rsp_ch.payload.wasted_total, want.wasted_total);
        check_field("misaligned", rsp_ch.payload.misaligned, want.misaligned);
        check_field("double_free", rsp_ch.payload.double_free, want.double_free);
        check_field("count_underflow", rsp_ch.payload.count_underflow,
                    want.count_underflow);
        outstanding--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: falling edge; a random gap, none when no_idle is set, follows each accepted request.
  // valid gets one assignment per edge so back-to-back requests keep it high.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      drive_vld = req_ch.valid;
      if (req_fired) begin
        drive_vld = 1'b0;
        send_gap  = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (!drive_vld) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_req.size() != 0) begin
          req_ch.payload <= pending_req.pop_front();
          drive_vld = 1'b1;
        end
      end
      req_ch.valid <= drive_vld;
    end
  end

  // Receiver: a random stall after each result (none when no_idle is set), plus the long hold-off below
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_fired) take_wait = no_idle ? 0 : $urandom_range(0, 4);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
      end else if (take_wait != 0) begin
        take_wait--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Back-pressure: once well into the run, refuse results while the driver keeps
  // offering, so the block backs up and drops req ready
  initial begin
    wait (n_accepted >= 800);
    @(posedge clk_i);
    hold_rsp = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_rsp = 1'b0;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input req_t r);
    pending_req.push_back(r);
    outstanding++;
  endtask

  // Unused field carries noise so every bit of it toggles
  task automatic push_alloc(input logic [REQ_W-1:0] size);
    req_t r;
    r.mode         = MODE_ALLOC;
    r.request_size = size;
    r.free_offset  = OFF_W'($urandom);
    queue_item(r);
  endtask

  task automatic push_free(input logic [OFF_W-1:0] off);
    req_t r;
    r.mode         = MODE_FREE;
    r.request_size = REQ_W'($urandom);
    r.free_offset  = off;
    queue_item(r);
  endtask

  // Register writes only while nothing is in flight; the predictor follows at once
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SLOT_COUNT) pool_count_reg = val;
    else pool_log2_reg = val[SZL_W-1:0];
  endtask

  // Random request, mostly well formed for the current pool shape.
  // Frees aim at the low slots that this phase's allocates have most likely taken.
  function automatic req_t gen_random(input int unsigned pct_free);
    req_t            r;
    int unsigned     n;
    int unsigned     hi;
    int unsigned     sel;
    longint unsigned slot_bytes;
    longint unsigned cap;
    longint unsigned limit;
    longint unsigned off;
    n          = (pool_slots() == 0) ? 1 : pool_slots();
    slot_bytes = 64'd1 << pool_log2_reg;
    cap        = (slot_bytes > 32767) ? 32767 : slot_bytes;
    limit      = longint'(pool_slots()) << pool_log2_reg;
    sel        = $urandom_range(0, 99);
    r.request_size = REQ_W'($urandom);
    r.free_offset  = OFF_W'($urandom);
    if ($urandom_range(0, 99) < pct_free) begin
      r.mode = MODE_FREE;
      hi  = (allocs_issued == 0) ? 1 : ((allocs_issued > n) ? n : allocs_issued);
      off = longint'($urandom_range(0, hi - 1)) << pool_log2_reg;
      if (sel < 75) begin
        r.free_offset = OFF_W'(off);
      end else if (sel < 87) begin
        if (slot_bytes > 1) off = off | $urandom_range(1, int'(slot_bytes - 1));
        r.free_offset = OFF_W'(off);
      end else if (sel < 95 && limit < OFF_SPAN) begin
        // just beyond the pool, up to the top of the offset range
        r.free_offset = OFF_W'(limit + ($urandom % (OFF_SPAN - limit)));
      end
    end else begin
      r.mode = MODE_ALLOC;
      allocs_issued++;
      if (sel < 80) r.request_size = REQ_W'($urandom_range(0, int'(cap)));
      else if (sel < 90) r.request_size = REQ_W'(cap);
      else if (sel < 96 && slot_bytes < 32767)
        r.request_size = REQ_W'($urandom_range(int'(slot_bytes) + 1, 32767));
    end
    return r;
  endfunction

  task automatic run_phase(input logic [CNT_W-1:0] count, input logic [SZL_W-1:0] log2,
                           input int items, input int unsigned pct_free, input bit quiet);
    // idle point: every result back, then a margin before the register writes
    wait (outstanding == 0);
    repeat (4) @(negedge clk_i);
    write_reg(REG_SLOT_COUNT, count);
    write_reg(REG_SLOT_SIZE_LOG2, CFG_DATA_W'(log2));
    no_idle       = quiet;
    allocs_issued = 0;
    repeat (items) queue_item(gen_random(pct_free));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_SLOT_COUNT;
    cfg_data_i     = '0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    drive_vld      = 1'b0;
    foreach (free_bits[i]) free_bits[i] = 1'b1;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, at the reset register values (1024 slots of 512 bytes).
    // The driver waits out the clearing pass on its own through req ready.
    push_alloc(15'd0);                      // slot 0, full slot wasted
    push_alloc(15'd512);                    // exact fit, slot 1
    push_alloc(15'd513);                    // just too big
    push_alloc(15'h7FFF);                   // largest request, too big
    push_free(25'd0);                       // release slot 0, becomes the hint
    push_alloc(15'd100);                    // hint taken; next slot busy
    push_alloc(15'd1);                      // lowest free slot
    push_free(25'd513);                     // misaligned free of slot 1
    push_free(25'd512);                     // same slot again: double free
    push_free(25'h1FF_FFFF);                // beyond the pool: not owned
    push_free(25'(1023 * 512 + 511));       // last byte of the last slot

    // Two one-byte slots: full with a stale map, underflow, hint reuse
    run_phase(11'd2, 4'd0, 0, 0, 1'b0);
    push_alloc(15'd1);                      // exact fit
    push_alloc(15'd2);                      // too big for a one-byte slot
    push_alloc(15'd0);                      // count below limit yet no free slot
    push_free(25'd0);
    push_free(25'd0);                       // double free with count at zero
    push_free(25'd2);                       // first offset past the pool
    push_alloc(15'd0);                      // hint reused

    // Zero slots: nothing can be allocated or owned
    run_phase(11'd0, 4'd3, 0, 0, 1'b0);
    push_alloc(15'd0);
    push_free(25'd0);

    // Over-range count clipped to the full pool, largest slot size
    run_phase(11'h7FF, 4'd15, 0, 0, 1'b0);
    push_alloc(15'h7FFF);
    push_alloc(15'd0);
    push_free(25'h1FF_FFFF);                // last byte of the clipped pool, misaligned

    // Random phases: small pools churn through full, hint and double-free paths
    run_phase(11'd16,   4'd4,  300, 40, 1'b0);
    run_phase(11'd4,    4'd0,  200, 45, 1'b1);
    run_phase(11'd1,    4'd15, 150, 50, 1'b0);
    run_phase(11'd1024, 4'd9,  600, 20, 1'b0);  // receiver hold-off lands here
    run_phase(11'd64,   4'd3,  300, 50, 1'b0);
    run_phase(11'h7FF,  4'd15, 200, 30, 1'b0);
    run_phase(11'd0,    4'd2,   50, 50, 1'b0);
    run_phase(11'd1000, 4'd6,  200, 50, 1'b1);

    wait (outstanding == 0);
    repeat (20) @(negedge clk_i);
    if (expected_rsp.size() != 0)
      report_mismatch("results never delivered", expected_rsp.size(), 0);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
